/* rtl/core/fba_pkg.sv */
package fba_pkg;

    // field widths
    localparam int FRAME_W   = 12;
    localparam int LIMIT_W   = 13;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int MAXF_W    = 21;

    // highest frame count reachable by the frame field
    localparam int FRAME_REACH = 4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOP     = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;

    // packed result fields, highest bit first
    typedef struct packed {
        logic [1:0]         status;
        logic               user_bit;
        logic               rw_bit;
        logic               present_bit;
        logic [FRAME_W-1:0] frame_out;
    } t_result;

    // shared bit finder outcome
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_find;

endpackage

/* rtl/core/frame_bitmap_allocator_unit.sv */
// First-fit page frame allocator over a bitmap with one used bit per frame,
// all frames free after reset. A request is taken only while the sequencer is
// idle. Requests that need no bitmap access (allocate for an entry that
// already holds a frame, free of frame 0 or of a frame past MAX_FRAMES) go
// straight to the result; a free reads the bitmap word, then writes it back.
// An allocate first scans the 32-word groups (up to 4 at the default size)
// of per-word full flags with the shared lowest-set-bit finder until a word
// with a free frame shows up; the same finder then picks the bit in that
// word, which is read and written back. When every group is scanned without a
// usable word, the allocate reports no free frame. A finished result sits
// in an output register, and the sequencer holds in its last step while that
// register is still occupied.
module frame_bitmap_allocator_unit
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config: frame_limit
    input  logic         i_cfg_wen,
    input  logic [12:0]  i_cfg_wdata,
    // request stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // entry_frame[11:0], writable_req[12], kernel_req[13]
    input  logic         i_s_tuser,   // action
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [23:0]  o_m_tdata    // frame_out[11:0], present_bit[12], rw_bit[13],
                                      // user_bit[14], status[16:15]
);

    localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int REACH_WDS  = FRAME_REACH / WORD_BITS;
    localparam int USED_WORDS = (MAP_WORDS < REACH_WDS) ? MAP_WORDS : REACH_WDS;
    localparam int WORD_W     = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
    localparam int GROUPS     = (USED_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int FIDX_W     = FRAME_W - BIT_W;
    localparam int CAP        = (MAX_FRAMES < FRAME_REACH) ? MAX_FRAMES : FRAME_REACH;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [LIMIT_W-1:0]    r_limit;
    logic                  r_action;
    logic [FRAME_W-1:0]    r_entry;
    logic                  r_wr, r_kern;
    logic [GRP_W-1:0]      r_grp, n_grp;
    logic [FIDX_W-1:0]     r_word, n_word;
    t_result               r_res, n_res;
    logic                  r_out_valid;
    t_result               r_out;

    logic [WORD_BITS-1:0]  mem [USED_WORDS];
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_rd_valid;
    logic [USED_WORDS-1:0] r_valid;
    logic [USED_WORDS-1:0] r_full;

    logic [LIMIT_W-1:0]    bound;
    logic [FIDX_W:0]       bound_words;
    logic [GROUPS*WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0]  word_now;
    logic [WORD_BITS-1:0]  find_vec;
    t_find                 find;
    logic [FRAME_W-1:0]    pick_frame;
    logic                  mem_we;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  in_fire;
    logic                  out_load;
    logic [WORD_W-1:0]     waddr;

    assign waddr      = r_word[WORD_W-1:0];
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(24 - $bits(t_result)){1'b0}}, r_out};

    // search bound and words it covers
    always_comb begin
        bound = (r_limit < LIMIT_W'(CAP)) ? r_limit : LIMIT_W'(CAP);
        bound_words = (FIDX_W + 1)'((14'(bound) + 14'(WORD_BITS - 1)) >> BIT_W);
    end

    // words worth looking into
    always_comb begin
        avail = '0;
        for (int w = 0; w < USED_WORDS; w++) begin
            avail[w] = !r_full[w] && ((FIDX_W + 1)'(w) < bound_words);
        end
    end

    // bitmap word as read, unwritten words are all free
    assign word_now = r_rd_valid ? r_rd_data : '0;

    // shared finder: full flags while scanning, free bits afterwards
    assign find_vec = (r_state == S_SCAN) ? avail[r_grp*WORD_BITS +: WORD_BITS] : ~word_now;

    fba_lsb_find u_find (
        .i_vec  (find_vec),
        .o_find (find)
    );

    assign pick_frame = {r_word, find.idx};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_grp     = r_grp;
        n_word    = r_word;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_wdata = word_now;
        unique case (r_state)
            S_IDLE: begin
                n_res = '0;
                n_grp = '0;
                n_word = i_s_tdata[FRAME_W-1:BIT_W];
                if (in_fire) begin
                    if (i_s_tuser == ACT_ALLOC) begin
                        if (i_s_tdata[FRAME_W-1:0] != '0) begin
                            n_res.frame_out = i_s_tdata[FRAME_W-1:0];
                            n_res.status    = ST_NOP;
                            n_state         = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_s_tdata[FRAME_W-1:0] == '0) begin
                            n_res.status = ST_NOP;
                            n_state      = S_DONE;
                        end else if (MAXF_W'(i_s_tdata[FRAME_W-1:0]) < MAXF_W'(MAX_FRAMES)) begin
                            n_state = S_RD;
                        end else begin
                            n_res.status = ST_DONE;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (find.found) begin
                    n_word  = FIDX_W'((32'(r_grp) << BIT_W) | 32'(find.idx));
                    n_state = S_RD;
                end else if (r_grp == GRP_W'(GROUPS - 1)) begin
                    n_res.status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_grp = r_grp + 1'b1;
                end
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                n_state = S_DONE;
                if (r_action == ACT_FREE) begin
                    mem_we                = 1'b1;
                    mem_wdata             = word_now;
                    mem_wdata[r_entry[BIT_W-1:0]] = 1'b0;
                    n_res.status          = ST_DONE;
                end else if (find.found && (13'(pick_frame) < bound)) begin
                    mem_we                = 1'b1;
                    mem_wdata             = word_now;
                    mem_wdata[find.idx]   = 1'b1;
                    n_res.frame_out       = pick_frame;
                    n_res.present_bit     = 1'b1;
                    n_res.rw_bit          = r_wr;
                    n_res.user_bit        = ~r_kern;
                    n_res.status          = ST_DONE;
                end else begin
                    n_res.status = ST_NO_FREE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // bitmap memory, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= mem_wdata;
        end
        r_rd_data <= mem[waddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_valid     <= '0;
            r_full      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= r_valid[waddr];
            if (i_cfg_wen) begin
                r_limit <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_valid[waddr] <= 1'b1;
                r_full[waddr]  <= (mem_wdata == '1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request fields and working payload
    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_word <= n_word;
        r_res  <= n_res;
        if (in_fire) begin
            r_action <= i_s_tuser;
            r_entry  <= i_s_tdata[FRAME_W-1:0];
            r_wr     <= i_s_tdata[FRAME_W];
            r_kern   <= i_s_tdata[FRAME_W+1];
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

endmodule

/* rtl/core/fba_lsb_find.sv */
module fba_lsb_find
    import fba_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_vec,
    output t_find                o_find
);

    // lowest set bit wins
    always_comb begin
        o_find = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_find.found = 1'b1;
                o_find.idx   = BIT_W'(i);
            end
        end
    end

endmodule
